### hw/rtl/nfca_pkg.sv
package nfca_pkg;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOM  = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Row-wide commands broadcast to every cell.
  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_INIT    = 3'd1;
  localparam logic [2:0] CMD_WRITE   = 3'd2;
  localparam logic [2:0] CMD_REMOVE  = 3'd3;
  localparam logic [2:0] CMD_INSERT  = 3'd4;
  localparam logic [2:0] CMD_SCAN    = 3'd5;

  localparam int ADDR_W = 17;

endpackage

### hw/rtl/next_fit_coalescing_allocator.sv
// Next-fit heap allocator with coalescing of free extents.
// Input channel in_*: one request per beat, tuser = req_type (0 alloc, 1 free),
// tdata = {address, size_bytes}. Output channel out_*: one result per request,
// tdata = {block_address, status}.
// Free extents live in a row of cells that rotates one place per cycle over the
// occupied cells; a search walks the row through cell 0. Allocate turns the row
// from the rover round to natural order; free makes one full turn to locate the
// slot. Block headers sit in a RAM indexed by header unit.
// After reset the block sweeps the header RAM to zero, one entry per cycle,
// and accepts no request until done; the extent row then holds one extent
// covering the whole heap.
// One request is in flight at a time. A result waits in the output register
// while out_tready is low; the next request is taken only after it is delivered.
module next_fit_coalescing_allocator #(
  parameter int HEAP_UNITS  = 8192,
  parameter int UNIT_BYTES  = 16,
  parameter int MAX_EXTENTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // size_bytes[16:0], address[33:17]
  input  logic        in_tuser,  // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // status[1:0], block_address[18:2]
);

  localparam int UW  = $clog2(HEAP_UNITS);
  localparam int LW  = UW + 1;
  localparam int XW  = $clog2(MAX_EXTENTS);
  localparam int CW  = XW + 1;
  localparam int SH  = $clog2(UNIT_BYTES);
  localparam int AW  = nfca_pkg::ADDR_W;
  localparam int WW  = (UW > AW ? UW : AW) + 2;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_AROT = 4'd2;
  localparam logic [3:0] S_ASCN = 4'd3;
  localparam logic [3:0] S_AFIX = 4'd4;
  localparam logic [3:0] S_FRD  = 4'd5;
  localparam logic [3:0] S_FHD  = 4'd6;
  localparam logic [3:0] S_FSCN = 4'd7;
  localparam logic [3:0] S_FROT = 4'd8;
  localparam logic [3:0] S_FAPP = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;
  localparam logic [3:0] S_FDEL = 4'd11;

  logic [3:0]    state_r, state_nxt;
  logic [UW-1:0] clr_r, clr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [XW-1:0] rover_r, rover_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] rot_r, rot_nxt;
  logic [LW-1:0] need_r, need_nxt;
  logic [UW-1:0] u_r, u_nxt;
  logic [LW-1:0] flen_r, flen_nxt;
  logic          found_r, found_nxt;
  logic [1:0]    st_r, st_nxt;
  logic [AW-1:0] ba_r, ba_nxt;
  logic [UW-1:0] hs_r, hs_nxt;
  logic [LW-1:0] hl_r, hl_nxt;
  logic [UW-1:0] ps_r, ps_nxt;
  logic [LW-1:0] pl_r, pl_nxt;

  logic [2:0]    cmd;
  logic [XW-1:0] sel_idx;
  logic          sel_any;
  logic [UW-1:0] wr_start;
  logic [LW-1:0] wr_len;

  logic [UW-1:0] cs [MAX_EXTENTS];
  logic [LW-1:0] cl [MAX_EXTENTS];

  // Extent row as a ring over the occupied cells: cell i takes from i+1 on scan.
  for (genvar i = 0; i < MAX_EXTENTS; i++) begin : g_cell
    localparam int HI = (i + 1) % MAX_EXTENTS;
    localparam int LO = (i + MAX_EXTENTS - 1) % MAX_EXTENTS;
    logic          c_sel, c_sh;
    logic [UW-1:0] c_hs;
    logic [LW-1:0] c_hl;
    assign c_sel = sel_any && (sel_idx == XW'(i));
    assign c_hs  = (CW'(i + 1) == cnt_r) ? cs[0] : cs[HI];
    assign c_hl  = (CW'(i + 1) == cnt_r) ? cl[0] : cl[HI];
    always_comb begin
      c_sh = 1'b0;
      if (cmd == nfca_pkg::CMD_REMOVE) begin
        c_sh = (XW'(i) >= sel_idx) && (CW'(i) < cnt_r);
      end else if (cmd == nfca_pkg::CMD_INSERT) begin
        c_sh = (XW'(i) > sel_idx) && (CW'(i) <= cnt_r);
      end
    end
    nfca_cell #(.UW(UW), .LW(LW)) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .sel        (c_sel),
      .shift_en   (c_sh),
      .wr_start   (wr_start),
      .wr_len     (wr_len),
      .init_start ('0),
      .init_len   ((i == 0) ? LW'(HEAP_UNITS) : '0),
      .lo_start   (cs[LO]),
      .lo_len     (cl[LO]),
      .hi_start   (c_hs),
      .hi_len     (c_hl),
      .start_r    (cs[i]),
      .len_r      (cl[i])
    );
  end

  logic          hd_we;
  logic [UW-1:0] hd_waddr, hd_raddr;
  logic [LW-1:0] hd_wdata, hd_rdata;

  nfca_ram #(.WIDTH(LW), .DEPTH(HEAP_UNITS)) u_hdr (
    .clk   (clk),
    .we    (hd_we),
    .waddr (hd_waddr),
    .wdata (hd_wdata),
    .raddr (hd_raddr),
    .rdata (hd_rdata)
  );

  logic [AW-1:0] in_size, in_addr;
  assign in_size = in_tdata[16:0];
  assign in_addr = in_tdata[33:17];

  logic [AW:0]   need_u;
  logic [WW-1:0] fu_wide;
  logic          addr_bad;
  logic [UW-1:0] rd_unit;

  always_comb begin
    need_u = ((AW+1)'(in_size) + (AW+1)'(UNIT_BYTES - 1)) >> SH;
    if (need_u == '0) need_u = (AW+1)'(1);
    need_u = need_u + (AW+1)'(1);
    fu_wide  = WW'(in_addr >> SH) - WW'(1);
    addr_bad = (in_addr < AW'(UNIT_BYTES)) || (in_addr[SH-1:0] != '0) ||
               (fu_wide >= WW'(HEAP_UNITS));
    rd_unit  = fu_wide[UW-1:0];
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {5'd0, ba_r, st_r};

  // During scans, physical cell 0 always shows logical entry (rot_r).
  logic [CW-1:0] rot_inc;
  logic [XW-1:0] pred_idx;
  logic          join_prev, join_next;
  always_comb begin
    rot_inc   = (rot_r + CW'(1) >= cnt_r) ? '0 : rot_r + CW'(1);
    pred_idx  = (pos_r == '0) ? XW'(cnt_r - CW'(1)) : XW'(pos_r - CW'(1));
    join_prev = (pos_r != '0) &&
                ((LW+2)'(ps_r) + (LW+2)'(pl_r) == (LW+2)'(u_r));
    join_next = (pos_r < cnt_r) &&
                ((LW+2)'(u_r) + (LW+2)'(flen_r) == (LW+2)'(hs_r));
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cnt_nxt   = cnt_r;
    rover_nxt = rover_r;
    k_nxt     = k_r;
    pos_nxt   = pos_r;
    rot_nxt   = rot_r;
    need_nxt  = need_r;
    u_nxt     = u_r;
    flen_nxt  = flen_r;
    found_nxt = found_r;
    st_nxt    = st_r;
    ba_nxt    = ba_r;
    hs_nxt    = hs_r;
    hl_nxt    = hl_r;
    ps_nxt    = ps_r;
    pl_nxt    = pl_r;
    cmd       = nfca_pkg::CMD_NONE;
    sel_idx   = '0;
    sel_any   = 1'b0;
    wr_start  = '0;
    wr_len    = '0;
    hd_we     = 1'b0;
    hd_waddr  = u_r;
    hd_wdata  = '0;
    hd_raddr  = u_r;
    case (state_r)
      S_CLR: begin
        cmd      = nfca_pkg::CMD_INIT;
        hd_we    = 1'b1;
        hd_waddr = clr_r;
        clr_nxt  = clr_r + UW'(1);
        if (clr_r == UW'(HEAP_UNITS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        hd_raddr = rd_unit;
        if (in_tvalid) begin
          k_nxt   = '0;
          rot_nxt = '0;
          if (in_tuser == nfca_pkg::REQ_ALLOC) begin
            need_nxt  = (need_u > (AW+1)'(HEAP_UNITS)) ? '1 : LW'(need_u);
            found_nxt = 1'b0;
            if (cnt_r == '0) begin
              st_nxt = nfca_pkg::ST_OOM; ba_nxt = '0; state_nxt = S_OUT;
            end else begin
              // rotate so cell 0 holds entry (rover+1) mod cnt
              pos_nxt   = (CW'(rover_r) + CW'(1) >= cnt_r) ? '0 :
                          CW'(rover_r) + CW'(1);
              state_nxt = S_AROT;
            end
          end else begin
            u_nxt = rd_unit;
            if (addr_bad) begin
              st_nxt = nfca_pkg::ST_BAD; ba_nxt = '0; state_nxt = S_OUT;
            end else begin
              state_nxt = S_FRD;
            end
          end
        end
      end
      S_AROT: begin
        if (rot_r == pos_r) begin
          state_nxt = S_ASCN;
        end else begin
          cmd     = nfca_pkg::CMD_SCAN;
          rot_nxt = rot_inc;
        end
      end
      S_ASCN: begin
        if (!found_r && k_r < cnt_r && cl[0] >= need_r) begin
          found_nxt = 1'b1;
          pos_nxt   = rot_r;
          hs_nxt    = cs[0];
          hl_nxt    = cl[0];
          u_nxt     = UW'(cs[0] + UW'(cl[0] - need_r));
        end
        // keep turning until every entry is seen and natural order is back
        cmd     = nfca_pkg::CMD_SCAN;
        rot_nxt = rot_inc;
        k_nxt   = k_r + CW'(1);
        if (rot_inc == '0 && k_r + CW'(1) >= cnt_r) begin
          if (found_nxt) begin
            state_nxt = S_AFIX;
          end else begin
            st_nxt = nfca_pkg::ST_OOM; ba_nxt = '0; state_nxt = S_OUT;
          end
        end
      end
      S_AFIX: begin
        hd_we    = 1'b1;
        hd_waddr = u_r;
        hd_wdata = need_r;
        sel_idx  = XW'(pos_r);
        sel_any  = 1'b1;
        if (hl_r == need_r) begin
          cmd     = nfca_pkg::CMD_REMOVE;
          cnt_nxt = cnt_r - CW'(1);
          if (cnt_r == CW'(1)) rover_nxt = '0;
          else rover_nxt = (pred_idx > XW'(pos_r)) ? pred_idx - XW'(1) : pred_idx;
        end else begin
          cmd       = nfca_pkg::CMD_WRITE;
          wr_start  = hs_r;
          wr_len    = hl_r - need_r;
          rover_nxt = pred_idx;
        end
        st_nxt    = nfca_pkg::ST_OK;
        ba_nxt    = AW'((WW'(u_r) + WW'(1)) << SH);
        state_nxt = S_OUT;
      end
      S_FRD: begin
        state_nxt = S_FHD;
      end
      S_FHD: begin
        flen_nxt = hd_rdata;
        if (hd_rdata == '0) begin
          st_nxt = nfca_pkg::ST_BAD; ba_nxt = '0; state_nxt = S_OUT;
        end else if (cnt_r == '0) begin
          pos_nxt = '0; state_nxt = S_FAPP;
        end else begin
          pos_nxt = cnt_r; found_nxt = 1'b0; state_nxt = S_FSCN;
        end
      end
      S_FSCN: begin
        // first entry whose start is not below u; hold its lower neighbor
        if (!found_r) begin
          if (cs[0] >= u_r) begin
            found_nxt = 1'b1;
            pos_nxt   = rot_r;
            hs_nxt    = cs[0];
            hl_nxt    = cl[0];
          end else begin
            ps_nxt = cs[0];
            pl_nxt = cl[0];
          end
        end
        cmd     = nfca_pkg::CMD_SCAN;
        rot_nxt = rot_inc;
        if (rot_inc == '0) state_nxt = S_FAPP;
      end
      S_FAPP: begin
        st_nxt    = nfca_pkg::ST_OK;
        ba_nxt    = '0;
        state_nxt = S_OUT;
        if (join_prev && join_next) begin
          // grow prev now, drop the upper neighbor next cycle
          sel_any   = 1'b1;
          sel_idx   = pred_idx;
          cmd       = nfca_pkg::CMD_WRITE;
          wr_start  = ps_r;
          wr_len    = LW'(pl_r + flen_r + hl_r);
          state_nxt = S_FDEL;
          if (CW'(rover_r) == pos_r) rover_nxt = pred_idx;
          else if (CW'(rover_r) > pos_r) rover_nxt = rover_r - XW'(1);
          hd_we = 1'b1;
        end else if (join_next) begin
          sel_any  = 1'b1;
          sel_idx  = XW'(pos_r);
          cmd      = nfca_pkg::CMD_WRITE;
          wr_start = u_r;
          wr_len   = LW'(hl_r + flen_r);
          if (CW'(rover_r) == pos_r) rover_nxt = pred_idx;
          hd_we = 1'b1;
        end else if (join_prev) begin
          sel_any  = 1'b1;
          sel_idx  = pred_idx;
          cmd      = nfca_pkg::CMD_WRITE;
          wr_start = ps_r;
          wr_len   = LW'(pl_r + flen_r);
          hd_we = 1'b1;
        end else if (cnt_r >= CW'(MAX_EXTENTS)) begin
          st_nxt = nfca_pkg::ST_FULL;
        end else begin
          sel_any  = 1'b1;
          sel_idx  = XW'(pos_r);
          cmd      = nfca_pkg::CMD_INSERT;
          wr_start = u_r;
          wr_len   = flen_r;
          if (cnt_r != '0 && CW'(rover_r) >= pos_r) rover_nxt = rover_r + XW'(1);
          cnt_nxt = cnt_r + CW'(1);
          hd_we = 1'b1;
        end
      end
      S_FDEL: begin
        // drop the absorbed upper neighbor of a double merge
        sel_any   = 1'b1;
        sel_idx   = XW'(pos_r);
        cmd       = nfca_pkg::CMD_REMOVE;
        cnt_nxt   = cnt_r - CW'(1);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      cnt_r   <= CW'(1);
      rover_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      rover_r <= rover_nxt;
    end
    k_r     <= k_nxt;
    pos_r   <= pos_nxt;
    rot_r   <= (!rst_n) ? '0 : rot_nxt;
    need_r  <= need_nxt;
    u_r     <= u_nxt;
    flen_r  <= flen_nxt;
    found_r <= found_nxt;
    st_r    <= st_nxt;
    ba_r    <= ba_nxt;
    hs_r    <= hs_nxt;
    hl_r    <= hl_nxt;
    ps_r    <= ps_nxt;
    pl_r    <= pl_nxt;
  end

endmodule

### hw/rtl/nfca_ram.sv
module nfca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/nfca_cell.sv
module nfca_cell #(
  parameter int UW = 14,
  parameter int LW = 14
) (
  input  logic          clk,
  input  logic [2:0]    cmd,
  input  logic          sel,
  input  logic          shift_en,
  input  logic [UW-1:0] wr_start,
  input  logic [LW-1:0] wr_len,
  input  logic [UW-1:0] init_start,
  input  logic [LW-1:0] init_len,
  input  logic [UW-1:0] lo_start,
  input  logic [LW-1:0] lo_len,
  input  logic [UW-1:0] hi_start,
  input  logic [LW-1:0] hi_len,
  output logic [UW-1:0] start_r,
  output logic [LW-1:0] len_r
);

  logic [UW-1:0] start_nxt;
  logic [LW-1:0] len_nxt;

  always_comb begin
    start_nxt = start_r;
    len_nxt   = len_r;
    case (cmd)
      nfca_pkg::CMD_INIT: begin
        start_nxt = init_start;
        len_nxt   = init_len;
      end
      nfca_pkg::CMD_WRITE: begin
        if (sel) begin
          start_nxt = wr_start;
          len_nxt   = wr_len;
        end
      end
      nfca_pkg::CMD_REMOVE: begin
        if (shift_en) begin
          start_nxt = hi_start;
          len_nxt   = hi_len;
        end
      end
      nfca_pkg::CMD_INSERT: begin
        if (sel) begin
          start_nxt = wr_start;
          len_nxt   = wr_len;
        end else if (shift_en) begin
          start_nxt = lo_start;
          len_nxt   = lo_len;
        end
      end
      nfca_pkg::CMD_SCAN: begin
        start_nxt = hi_start;
        len_nxt   = hi_len;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    len_r   <= len_nxt;
  end

endmodule
